@@ rtl/mono_page_framebuffer_draw_unit_assert.svh @@
// Assertion macros for the checker file of the draw unit.
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH

// Checked at every rising clock edge outside of reset.
`define MPFB_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked at every rising clock edge, reset included.
`define MPFB_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/mpfb_pkg.sv @@
package mpfb_pkg;

  localparam int unsigned MAX_WIDTH   = 128;
  localparam int unsigned MAX_HEIGHT  = 64;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * (MAX_HEIGHT / 8);

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PAGES_W = $clog2(MAX_HEIGHT / 8 + 1);

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = CFG_IDX_W'(1);

  localparam logic [7:0] DISPLAY_WIDTH_RST  = 8'd128;
  localparam logic [6:0] DISPLAY_HEIGHT_RST = 7'd64;

  typedef enum logic [2:0] {
    REQ_PIXEL = 3'd0,
    REQ_RECT  = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_FILL  = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic       pixel_on;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       ignored;
  } resp_t;

endpackage

@@ rtl/mono_page_framebuffer_draw_unit.sv @@
// A pixel request finishes in S_WR, a read in S_RDOUT, a refused request in S_IDLE.
// Clear and fill write each byte of the used area in S_FILL.
// A rectangle walks its top, bottom, left and right edges; each edge pixel on the display
// is a read-modify-write through the single frame memory; clipped pixels are skipped.
// A new beat is taken once the previous result is registered and the output is free, so
// requests do not overlap; after reset input stalls while S_CLR zeroes all 1024 bytes.
module mono_page_framebuffer_draw_unit
  import mpfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output resp_t                out_data_o
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_RDOUT = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  localparam logic [1:0] PASS_TOP    = 2'd0;
  localparam logic [1:0] PASS_BOTTOM = 2'd1;
  localparam logic [1:0] PASS_LEFT   = 2'd2;
  localparam logic [1:0] PASS_RIGHT  = 2'd3;

  function automatic logic [WIDTH_W-1:0] eff_width(logic [7:0] dw);
    if (int'(dw) > MAX_WIDTH) begin
      return WIDTH_W'(MAX_WIDTH);
    end
    return WIDTH_W'(dw);
  endfunction

  function automatic logic [PAGES_W-1:0] eff_pages(logic [6:0] dh);
    int unsigned h;
    h = (int'(dh) > MAX_HEIGHT) ? MAX_HEIGHT : int'(dh);
    return PAGES_W'(h >> 3);
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(logic [7:0] page, logic [7:0] x,
                                                  logic [WIDTH_W-1:0] w);
    logic [WIDTH_W+7:0] prod;
    prod = {{WIDTH_W{1'b0}}, page} * {8'b0, w};
    return ADDR_W'(prod + {{WIDTH_W{1'b0}}, x});
  endfunction

  logic [2:0]         state_q, state_d;
  logic [7:0]         disp_width_q;
  logic [6:0]         disp_height_q;
  req_t               req_q;
  logic [1:0]         pass_q, pass_d;
  logic [7:0]         idx_q, idx_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ADDR_W-1:0]  last_q, last_d;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         fill_val_q, fill_val_d;
  resp_t              res_q, res_d;
  logic               out_valid_q, out_valid_d;
  resp_t              out_data_q, out_data_d;

  logic [WIDTH_W-1:0] width;
  logic [PAGES_W-1:0] pages;
  logic [WIDTH_W+PAGES_W-1:0] area;
  logic               out_free;
  logic               in_acc;
  logic [7:0]         cur_x, cur_y;
  logic               cur_ok;
  logic               last_step;
  logic               adv_done;
  logic [7:0]         bit_mask;
  logic               fin;
  resp_t              fin_data;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  mpfb_ram #(
    .DATA_W(8),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign width    = eff_width(disp_width_q);
  assign pages    = eff_pages(disp_height_q);
  assign area     = {{WIDTH_W{1'b0}}, pages} * {{PAGES_W{1'b0}}, width};
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign bit_mask = 8'd1 << bit_q;

  always_comb begin
    case (pass_q)
      PASS_TOP: begin
        cur_x = idx_q;
        cur_y = req_q.y_first;
      end
      PASS_BOTTOM: begin
        cur_x = idx_q;
        cur_y = req_q.y_second;
      end
      PASS_LEFT: begin
        cur_x = req_q.x_first;
        cur_y = idx_q;
      end
      default: begin
        cur_x = req_q.x_second;
        cur_y = idx_q;
      end
    endcase
  end

  assign cur_ok = (int'(cur_x) < int'(width)) && (int'(cur_y[7:3]) < int'(pages));
  assign last_step = (pass_q == PASS_TOP || pass_q == PASS_BOTTOM) ?
                     (idx_q == req_q.x_second) : (idx_q == req_q.y_second);
  assign adv_done = last_step && (pass_q == PASS_RIGHT);

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    last_d      = last_q;
    bit_d       = bit_q;
    fill_val_d  = fill_val_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = fill_val_q;
    ram_raddr   = '0;
    fin         = 1'b0;
    fin_data    = '0;

    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = 8'd0;
        addr_d    = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.req_type)
            REQ_PIXEL: begin
              if ((int'(in_data_i.x_first) < int'(width)) &&
                  (int'(in_data_i.y_first[7:3]) < int'(pages))) begin
                ram_raddr = byte_addr({3'b0, in_data_i.y_first[7:3]}, in_data_i.x_first,
                                      width);
                addr_d    = ram_raddr;
                bit_d     = in_data_i.y_first[2:0];
                state_d   = S_WR;
              end else begin
                fin              = 1'b1;
                fin_data.ignored = 1'b1;
              end
            end
            REQ_RECT: begin
              if (in_data_i.x_first >= in_data_i.x_second ||
                  in_data_i.y_first >= in_data_i.y_second) begin
                fin              = 1'b1;
                fin_data.ignored = 1'b1;
              end else begin
                pass_d  = PASS_TOP;
                idx_d   = in_data_i.x_first;
                state_d = S_RD;
              end
            end
            REQ_CLEAR, REQ_FILL: begin
              if (area == '0) begin
                fin = 1'b1;
              end else begin
                addr_d     = '0;
                last_d     = ADDR_W'(area - 1'b1);
                fill_val_d = (in_data_i.req_type == REQ_FILL) ? 8'hFF : 8'h00;
                state_d    = S_FILL;
              end
            end
            REQ_READ: begin
              if ((int'(in_data_i.x_first) < int'(width)) &&
                  (int'(in_data_i.y_first) < int'(pages))) begin
                ram_raddr = byte_addr(in_data_i.y_first, in_data_i.x_first, width);
                state_d   = S_RDOUT;
              end else begin
                fin              = 1'b1;
                fin_data.ignored = 1'b1;
              end
            end
            default: begin
              fin              = 1'b1;
              fin_data.ignored = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        if (cur_ok) begin
          ram_raddr = byte_addr({3'b0, cur_y[7:3]}, cur_x, width);
          addr_d    = ram_raddr;
          bit_d     = cur_y[2:0];
          state_d   = S_WR;
        end else if (adv_done) begin
          fin = 1'b1;
        end else if (last_step) begin
          pass_d = pass_q + 2'd1;
          idx_d  = (pass_q == PASS_TOP) ? req_q.x_first : req_q.y_first;
        end else begin
          idx_d = idx_q + 8'd1;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = req_q.pixel_on ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        if (req_q.req_type == REQ_PIXEL || adv_done) begin
          fin = 1'b1;
        end else begin
          state_d = S_RD;
          if (last_step) begin
            pass_d = pass_q + 2'd1;
            idx_d  = (pass_q == PASS_TOP) ? req_q.x_first : req_q.y_first;
          end else begin
            idx_d = idx_q + 8'd1;
          end
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == last_q) begin
          fin = 1'b1;
        end
      end
      S_RDOUT: begin
        fin                = 1'b1;
        fin_data.read_byte = ram_rdata;
      end
      S_RESP: begin
        fin      = 1'b1;
        fin_data = res_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = fin_data;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_data;
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      addr_q        <= '0;
      out_valid_q   <= 1'b0;
      disp_width_q  <= DISPLAY_WIDTH_RST;
      disp_height_q <= DISPLAY_HEIGHT_RST;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DISPLAY_WIDTH: begin
            disp_width_q <= cfg_data_i;
          end
          REG_DISPLAY_HEIGHT: begin
            disp_height_q <= cfg_data_i[6:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    pass_q     <= pass_d;
    idx_q      <= idx_d;
    last_q     <= last_d;
    bit_q      <= bit_d;
    fill_val_q <= fill_val_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/mpfb_ram.sv @@
module mpfb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mpfb_checker.sv @@
`include "mono_page_framebuffer_draw_unit_assert.svh"

module mpfb_checker
  import mpfb_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_stall_o,
  input logic  out_valid_o,
  input logic  out_stall_i,
  input resp_t out_data_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_beat, out_beat;
  logic       room_ok;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;
  assign pend_d   = pend_q + {1'b0, in_beat} - {1'b0, out_beat};
  assign room_ok  = (pend_q == 2'd0) || (pend_q == 2'd1 && out_valid_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Every request yields one result, so at most the finished one may wait at the output.
  `MPFB_ASSERT(a_accept_room, in_beat |-> room_ok, clk_i, rst_ni)
  `MPFB_ASSERT(a_refused_no_data, out_valid_o && out_data_o.ignored |-> out_data_o.read_byte == 8'd0, clk_i, rst_ni)
  `MPFB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, clk_i, rst_ni)
  `MPFB_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), clk_i, rst_ni)
  `MPFB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && in_stall_o, clk_i)

endmodule

bind mono_page_framebuffer_draw_unit mpfb_checker u_mpfb_checker (.*);

@@ tb/sv/tb_mono_page_framebuffer_draw_unit.sv @@
`timescale 1ns / 100ps

module tb_mono_page_framebuffer_draw_unit;
  import mpfb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned DRAIN_POINT = 50;
  localparam int unsigned PRINT_CAP = 30;
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  class frame_scoreboard;
    logic [7:0] frame_bytes [STORE_DEPTH];
    logic [7:0] width_reg;
    logic [6:0] height_reg;
    resp_t expected_q[$];
    int unsigned mismatches;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      width_reg = DISPLAY_WIDTH_RST;
      height_reg = DISPLAY_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == REG_DISPLAY_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_DISPLAY_HEIGHT) begin
        height_reg = value[6:0];
      end
    endfunction

    function int unsigned cols();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int unsigned rows();
      int unsigned h;
      h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
      return h - h % 8;
    endfunction

    function bit plot(int unsigned x, int unsigned y, bit on);
      int unsigned addr;
      if (x >= cols() || y >= rows()) return 1'b0;
      addr = (y / 8) * cols() + x;
      frame_bytes[addr][y % 8] = on;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      resp_t want;
      int unsigned i;
      int unsigned used;
      want = '0;
      case (r.req_type)
        REQ_PIXEL: begin
          want.ignored = !plot(r.x_first, r.y_first, r.pixel_on);
        end
        REQ_RECT: begin
          if (r.x_first >= r.x_second || r.y_first >= r.y_second) begin
            want.ignored = 1'b1;
          end else begin
            for (i = r.x_first; i <= r.x_second; i++) begin
              void'(plot(i, r.y_first, r.pixel_on));
              void'(plot(i, r.y_second, r.pixel_on));
            end
            for (i = r.y_first; i <= r.y_second; i++) begin
              void'(plot(r.x_first, i, r.pixel_on));
              void'(plot(r.x_second, i, r.pixel_on));
            end
          end
        end
        REQ_CLEAR, REQ_FILL: begin
          used = cols() * (rows() / 8);
          for (i = 0; i < used; i++) begin
            frame_bytes[i] = (r.req_type == REQ_FILL) ? 8'hFF : 8'h00;
          end
        end
        REQ_READ: begin
          if (r.x_first >= cols() || r.y_first >= rows() / 8) begin
            want.ignored = 1'b1;
          end else begin
            want.read_byte = frame_bytes[r.y_first * cols() + r.x_first];
          end
        end
        default: begin
          want.ignored = 1'b1;
        end
      endcase
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_response(resp_t got);
      resp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = expected_q.pop_front();
        if (got.read_byte !== want.read_byte) begin
          report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
        end
        if (got.ignored !== want.ignored) begin
          report_mismatch($sformatf("ignored %b, want %b", got.ignored, want.ignored));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  resp_t out_data_o;

  frame_scoreboard frames = new();
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned disp_cols;
  int unsigned disp_rows;
  int unsigned disp_pages;
  int unsigned cycles;

  mono_page_framebuffer_draw_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) frames.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) frames.check_response(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [7:0] x1, logic [7:0] y1,
                                    logic [7:0] x2, logic [7:0] y2, logic on);
    req_t r;
    r.req_type = kind;
    r.x_first = x1;
    r.y_first = y1;
    r.x_second = x2;
    r.y_second = y2;
    r.pixel_on = on;
    return r;
  endfunction

  function automatic logic [7:0] pick(int unsigned lim);
    if (lim == 0 || $urandom_range(99) < 15) return 8'($urandom_range(255));
    return 8'($urandom_range(lim - 1));
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned roll;
    int unsigned far;
    roll = $urandom_range(99);
    r.pixel_on = 1'($urandom_range(1));
    r.x_first = pick(disp_cols);
    r.y_first = pick(disp_rows);
    r.x_second = 8'($urandom_range(255));
    r.y_second = 8'($urandom_range(255));
    if (roll < 40) begin
      r.req_type = REQ_PIXEL;
    end else if (roll < 52) begin
      r.req_type = REQ_RECT;
      if ($urandom_range(9) != 0) begin
        far = r.x_first + $urandom_range(14);
        r.x_second = (far > 255) ? 8'hFF : 8'(far);
        far = r.y_first + $urandom_range(14);
        r.y_second = (far > 255) ? 8'hFF : 8'(far);
      end
    end else if (roll < 55) begin
      r.req_type = REQ_CLEAR;
    end else if (roll < 58) begin
      r.req_type = REQ_FILL;
    end else if (roll < 93) begin
      r.req_type = REQ_READ;
      r.y_first = pick(disp_pages);
    end else begin
      r.req_type = 3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (frames.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(logic [7:0] width_val, logic [6:0] height_val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_DISPLAY_WIDTH;
    cfg_data_i <= width_val;
    @(posedge clk_i);
    frames.set_register(REG_DISPLAY_WIDTH, width_val);
    cfg_idx_i <= REG_DISPLAY_HEIGHT;
    cfg_data_i <= 8'(height_val);
    @(posedge clk_i);
    frames.set_register(REG_DISPLAY_HEIGHT, 8'(height_val));
    cfg_we_i <= 1'b0;
    disp_cols = frames.cols();
    disp_rows = frames.rows();
    disp_pages = disp_rows / 8;
  endtask

  initial begin
    req_t directed_q[$];
    logic [7:0] width_set [PHASES];
    logic [6:0] height_set [PHASES];
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];

    width_set = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd73, 8'd128, 8'd16, 8'd200};
    height_set = '{7'd64, 7'd8, 7'd127, 7'd0, 7'd40, 7'd63, 7'd13, 7'd64};
    phase_idle = '{0, 48, 0, 31};
    phase_stall = '{0, 0, 48, 31};

    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    disp_cols = MAX_WIDTH;
    disp_rows = MAX_HEIGHT;
    disp_pages = MAX_HEIGHT / 8;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_DISPLAY_WIDTH;
    cfg_data_i <= 8'h00;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_q.push_back(make_req(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, 1'b1));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    directed_q.push_back(make_req(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_READ, 8'd127, 8'd7, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_READ, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_READ, 8'd0, 8'd8, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_RECT, 8'd10, 8'd5, 8'd20, 8'd30, 1'b1));
    directed_q.push_back(make_req(REQ_RECT, 8'd40, 8'd5, 8'd40, 8'd30, 1'b1));
    directed_q.push_back(make_req(REQ_RECT, 8'd40, 8'd30, 8'd60, 8'd10, 1'b1));
    directed_q.push_back(make_req(REQ_RECT, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1));
    directed_q.push_back(make_req(REQ_RECT, 8'd200, 8'd100, 8'd255, 8'd255, 1'b1));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd10, 8'd5, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_READ, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_PIXEL, 8'd50, 8'd27, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_READ, 8'd50, 8'd3, 8'd0, 8'd0, 1'b0));
    directed_q.push_back(make_req(REQ_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    directed_q.push_back(make_req(REQ_READ, 8'd127, 8'd7, 8'd0, 8'd0, 1'b0));
    for (int k = REQ_UNKNOWN_LO; k <= REQ_UNKNOWN_HI; k++) begin
      directed_q.push_back(make_req(3'(k), 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    end
    foreach (directed_q[i]) send_request(directed_q[i]);
    in_valid_i <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      write_config(width_set[p], height_set[p]);
      idle_pct = phase_idle[p % 4];
      stall_pct = phase_stall[p % 4];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == DRAIN_POINT) begin
          in_valid_i <= 1'b0;
          wait_drain();
        end
        send_request(random_request());
      end
      in_valid_i <= 1'b0;
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (frames.expected_q.size() != 0) begin
      frames.report_mismatch($sformatf("%0d expected results never arrived",
                                       frames.expected_q.size()));
    end
    if (frames.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
